// File: src/rpry_pkg.sv
// ----------------------------------------------------------------------------
// rpry_pkg
// constants, arctangent table and start gain for the roll/pitch yaw rotation
// ----------------------------------------------------------------------------
package rpry_pkg;

	localparam int ANGLE_FRACTION_BITS = 7;
	localparam int CORDIC_STAGES       = 16;
	localparam int IFRAC               = 24;
	localparam int QBITS               = 30;
	localparam int TAB_LEN             = 32;
	localparam int N_ST     = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
	localparam int IN_SH    = IFRAC - ANGLE_FRACTION_BITS;
	localparam int SQ_STEPS = 32;

	localparam int W_IN  = 16;
	localparam int W_ANG = 35;
	localparam int W_V   = 36;
	localparam int W_Q   = 34;
	localparam int W_P   = 2 * W_Q;
	localparam int W_SQ  = 64;

	localparam logic signed [W_ANG-1:0] HALF_TURN    = W_ANG'(64'sd180 <<< IFRAC);
	localparam logic signed [W_ANG-1:0] QUARTER_TURN = W_ANG'(64'sd90 <<< IFRAC);
	localparam logic signed [W_ANG-1:0] FULL_TURN    = W_ANG'(64'sd360 <<< IFRAC);
	localparam logic signed [W_ANG-1:0] ROUND_HALF   = W_ANG'(64'sd1 <<< (IN_SH - 1));
	localparam logic signed [W_ANG-1:0] LIM_ROLL     =
		W_ANG'(64'sd90 <<< ANGLE_FRACTION_BITS);
	localparam logic signed [W_ANG-1:0] LIM_PITCH    =
		W_ANG'(64'sd180 <<< ANGLE_FRACTION_BITS);

	localparam logic signed [W_ANG-1:0] ATAN_TAB [TAB_LEN] = '{
		35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
		35'sd60000934, 35'sd30029717, 35'sd15018523, 35'sd7509720,
		35'sd3754917, 35'sd1877466, 35'sd938734, 35'sd469367,
		35'sd234684, 35'sd117342, 35'sd58671, 35'sd29335,
		35'sd14668, 35'sd7334, 35'sd3667, 35'sd1833,
		35'sd917, 35'sd458, 35'sd229, 35'sd115,
		35'sd57, 35'sd29, 35'sd14, 35'sd7,
		35'sd4, 35'sd2, 35'sd1, 35'sd0
	};

	// start value 2^61 / isqrt(2^62 * prod(1 + 4^-i)), rounded to nearest
	function automatic logic [63:0] gain_k();
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] num;
		logic [63:0] q;
		logic [64:0] rem;
		p = 64'd1 << 62;
		for (int i = 0; i < N_ST; i++) begin
			p = p + (p >> (2 * i));
		end
		v = p;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		num = (64'd1 << 61) + (r >> 1);
		q = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, r}) begin
				rem = rem - {1'b0, r};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	localparam logic signed [W_V-1:0] K_START = W_V'(gain_k());

endpackage

// File: src/roll_pitch_rotate_by_yaw.sv
// ----------------------------------------------------------------------------
// roll_pitch_rotate_by_yaw
// turns a roll/pitch head pose about the vertical axis by a yaw angle
// ----------------------------------------------------------------------------
// Input beats carry yaw, roll and pitch in 1/128 degree; each output beat
// carries the rotated roll (within +-90 degrees) and pitch (within +-180).
// One output beat follows every input beat, in order.
// Throughput: one beat per cycle while s_tready is high. The pipeline is
// the input register, 16 rotation CORDIC stages (yaw, roll and pitch side
// by side), a sign stage, two Q30 multiply rounds of two stages each, the
// squaring and sum stages, a 32-step square root and the roll vectoring
// CORDIC (one setup and 16 stages); the pitch vectoring CORDIC runs beside
// the root and is delayed to match.
// Reset clears every valid bit and the skid flag; no data register is reset.
// When m_tready is low the result waits in the output register and one more
// result is caught in a skid register; only then does s_tready drop and the
// whole pipeline hold. Nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module roll_pitch_rotate_by_yaw (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // yaw_angle, roll_angle, pitch_angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // roll_out, pitch_out, zero pad
);

	localparam int N      = rpry_pkg::N_ST;
	localparam int W_ANG  = rpry_pkg::W_ANG;
	localparam int W_V    = rpry_pkg::W_V;
	localparam int W_Q    = rpry_pkg::W_Q;
	localparam int W_P    = rpry_pkg::W_P;
	localparam int W_SQ   = rpry_pkg::W_SQ;
	localparam int QB     = rpry_pkg::QBITS;
	localparam int SQN    = rpry_pkg::SQ_STEPS;
	localparam int P_TRIG = 1 + N + 1;
	localparam int P_PRE  = P_TRIG + 5;
	localparam int P_SUM  = P_PRE + 1;
	localparam int P_RPRE = P_SUM + SQN + 1;
	localparam int P_LAST = P_RPRE + N;
	localparam int YD     = P_RPRE - P_PRE;
	localparam int PD     = P_LAST - P_PRE - N;

	logic en;
	logic [P_LAST:1] vld_s;
	logic skid_valid_q;
	logic [31:0] skid_q;
	logic [31:0] res;

	// reduce
	logic signed [rpry_pkg::W_IN-1:0] in_ang [3];
	logic signed [W_ANG-1:0] red_t [3];
	logic red_n [3];

	// rotation lanes: yaw, roll, pitch
	logic signed [W_V-1:0]   rx_s [3][0:N];
	logic signed [W_V-1:0]   ry_s [3][0:N];
	logic signed [W_ANG-1:0] rt_s [3][0:N];
	logic                    neg_s [3][0:N];

	logic signed [W_Q-1:0] cs_trig [3];
	logic signed [W_Q-1:0] sn_trig [3];
	logic signed [W_P-1:0] pa_m1, pc_m1;
	logic signed [W_Q-1:0] sr_m1, cy_m1, sy_m1;
	logic signed [W_Q-1:0] x_xyz, y_xyz, z_xyz, cy_xyz, sy_xyz;
	logic signed [W_P-1:0] p1_m2, p2_m2, p3_m2, p4_m2;
	logic signed [W_Q-1:0] z_m2;
	logic signed [W_Q-1:0] xr_rot, yr_rot, z_rot;

	logic signed [W_V-1:0]   pvx_s [0:N];
	logic signed [W_V-1:0]   pvy_s [0:N];
	logic signed [W_ANG-1:0] pacc_s [0:N];
	logic                    pz_s [0:N];
	logic signed [W_ANG-1:0] pacc_d [0:PD-1];
	logic                    pz_d [0:PD-1];

	logic signed [W_P-1:0] sqx_pre, sqz_pre;
	logic signed [W_Q-1:0] yr_d [0:YD-1];
	logic [W_SQ-1:0] sv_s [0:SQN];
	logic [W_SQ-1:0] sr_s [0:SQN];

	logic signed [W_V-1:0]   rvx_s [0:N];
	logic signed [W_V-1:0]   rvy_s [0:N];
	logic signed [W_ANG-1:0] racc_s [0:N];
	logic                    rz_s [0:N];

	logic signed [W_ANG-1:0] roll_fin, pitch_fin;
	logic [15:0] roll_fld, pitch_fld;

	function automatic logic [15:0] to_fld(input logic signed [W_ANG-1:0] v,
			input logic signed [W_ANG-1:0] lim);
		logic signed [W_ANG-1:0] q;
		q = (v + rpry_pkg::ROUND_HALF) >>> rpry_pkg::IN_SH;
		if (q > lim) q = lim;
		if (q < -lim) q = -lim;
		return q[15:0];
	endfunction

	assign en       = !skid_valid_q;
	assign s_tready = en;

	assign in_ang[0] = signed'(s_tdata[15:0]);
	assign in_ang[1] = signed'(s_tdata[31:16]);
	assign in_ang[2] = signed'(s_tdata[47:32]);

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			red_t[l] = W_ANG'(in_ang[l]) <<< rpry_pkg::IN_SH;
			red_n[l] = 1'b0;
			if (red_t[l] < -rpry_pkg::HALF_TURN) begin
				red_t[l] = red_t[l] + rpry_pkg::FULL_TURN;
			end else if (red_t[l] >= rpry_pkg::HALF_TURN) begin
				red_t[l] = red_t[l] - rpry_pkg::FULL_TURN;
			end
			if (red_t[l] > rpry_pkg::QUARTER_TURN) begin
				red_t[l] = red_t[l] - rpry_pkg::HALF_TURN;
				red_n[l] = 1'b1;
			end else if (red_t[l] < -rpry_pkg::QUARTER_TURN) begin
				red_t[l] = red_t[l] + rpry_pkg::HALF_TURN;
				red_n[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[P_LAST-1:1], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rx_s[l][0]  <= rpry_pkg::K_START;
				ry_s[l][0]  <= '0;
				rt_s[l][0]  <= red_t[l];
				neg_s[l][0] <= red_n[l];
				for (int j = 1; j <= N; j++) begin
					neg_s[l][j] <= neg_s[l][j-1];
					if (rt_s[l][j-1] >= 0) begin
						rx_s[l][j] <= rx_s[l][j-1] - (ry_s[l][j-1] >>> (j - 1));
						ry_s[l][j] <= ry_s[l][j-1] + (rx_s[l][j-1] >>> (j - 1));
						rt_s[l][j] <= rt_s[l][j-1] - rpry_pkg::ATAN_TAB[j-1];
					end else begin
						rx_s[l][j] <= rx_s[l][j-1] + (ry_s[l][j-1] >>> (j - 1));
						ry_s[l][j] <= ry_s[l][j-1] - (rx_s[l][j-1] >>> (j - 1));
						rt_s[l][j] <= rt_s[l][j-1] + rpry_pkg::ATAN_TAB[j-1];
					end
				end
				cs_trig[l] <= W_Q'(neg_s[l][N] ? -rx_s[l][N] : rx_s[l][N]);
				sn_trig[l] <= W_Q'(neg_s[l][N] ? -ry_s[l][N] : ry_s[l][N]);
			end

			// x = -sinP*cosR, y = -sinR, z = cosP*cosR
			pa_m1 <= W_P'(sn_trig[2]) * W_P'(cs_trig[1]);
			pc_m1 <= W_P'(cs_trig[2]) * W_P'(cs_trig[1]);
			sr_m1 <= sn_trig[1];
			cy_m1 <= cs_trig[0];
			sy_m1 <= sn_trig[0];

			x_xyz  <= W_Q'(-(pa_m1 >>> QB));
			z_xyz  <= W_Q'(pc_m1 >>> QB);
			y_xyz  <= -sr_m1;
			cy_xyz <= cy_m1;
			sy_xyz <= sy_m1;

			p1_m2 <= W_P'(x_xyz) * W_P'(cy_xyz);
			p2_m2 <= W_P'(y_xyz) * W_P'(sy_xyz);
			p3_m2 <= W_P'(y_xyz) * W_P'(cy_xyz);
			p4_m2 <= W_P'(x_xyz) * W_P'(sy_xyz);
			z_m2  <= z_xyz;

			xr_rot <= W_Q'((p1_m2 >>> QB) + (p2_m2 >>> QB));
			yr_rot <= W_Q'((p3_m2 >>> QB) - (p4_m2 >>> QB));
			z_rot  <= z_m2;

			// pitch = atan2(-x', z)
			pz_s[0] <= (xr_rot == '0) && (z_rot == '0);
			if (z_rot < 0) begin
				pacc_s[0] <= (xr_rot <= 0) ? rpry_pkg::HALF_TURN : -rpry_pkg::HALF_TURN;
				pvx_s[0]  <= -W_V'(z_rot);
				pvy_s[0]  <= W_V'(xr_rot);
			end else begin
				pacc_s[0] <= '0;
				pvx_s[0]  <= W_V'(z_rot);
				pvy_s[0]  <= -W_V'(xr_rot);
			end
			for (int j = 1; j <= N; j++) begin
				pz_s[j] <= pz_s[j-1];
				if (pvy_s[j-1] < 0) begin
					pvx_s[j]  <= pvx_s[j-1] - (pvy_s[j-1] >>> (j - 1));
					pvy_s[j]  <= pvy_s[j-1] + (pvx_s[j-1] >>> (j - 1));
					pacc_s[j] <= pacc_s[j-1] - rpry_pkg::ATAN_TAB[j-1];
				end else begin
					pvx_s[j]  <= pvx_s[j-1] + (pvy_s[j-1] >>> (j - 1));
					pvy_s[j]  <= pvy_s[j-1] - (pvx_s[j-1] >>> (j - 1));
					pacc_s[j] <= pacc_s[j-1] + rpry_pkg::ATAN_TAB[j-1];
				end
			end
			pacc_d[0] <= pacc_s[N];
			pz_d[0]   <= pz_s[N];
			for (int d = 1; d < PD; d++) begin
				pacc_d[d] <= pacc_d[d-1];
				pz_d[d]   <= pz_d[d-1];
			end

			// r = isqrt(x'^2 + z^2)
			sqx_pre <= W_P'(xr_rot) * W_P'(xr_rot);
			sqz_pre <= W_P'(z_rot) * W_P'(z_rot);
			yr_d[0] <= yr_rot;
			for (int d = 1; d < YD; d++) begin
				yr_d[d] <= yr_d[d-1];
			end
			sv_s[0] <= W_SQ'(sqx_pre + sqz_pre);
			sr_s[0] <= '0;
			for (int k = 1; k <= SQN; k++) begin
				if (sv_s[k-1] >= sr_s[k-1] + (W_SQ'(1) << (2 * SQN - 2 * k))) begin
					sv_s[k] <= sv_s[k-1] - (sr_s[k-1] + (W_SQ'(1) << (2 * SQN - 2 * k)));
					sr_s[k] <= (sr_s[k-1] >> 1) + (W_SQ'(1) << (2 * SQN - 2 * k));
				end else begin
					sv_s[k] <= sv_s[k-1];
					sr_s[k] <= sr_s[k-1] >> 1;
				end
			end

			// roll = atan2(-y', r), r never negative
			rz_s[0]   <= (yr_d[YD-1] == '0) && (sr_s[SQN] == '0);
			racc_s[0] <= '0;
			rvx_s[0]  <= signed'(W_V'(sr_s[SQN]));
			rvy_s[0]  <= -W_V'(yr_d[YD-1]);
			for (int j = 1; j <= N; j++) begin
				rz_s[j] <= rz_s[j-1];
				if (rvy_s[j-1] < 0) begin
					rvx_s[j]  <= rvx_s[j-1] - (rvy_s[j-1] >>> (j - 1));
					rvy_s[j]  <= rvy_s[j-1] + (rvx_s[j-1] >>> (j - 1));
					racc_s[j] <= racc_s[j-1] - rpry_pkg::ATAN_TAB[j-1];
				end else begin
					rvx_s[j]  <= rvx_s[j-1] + (rvy_s[j-1] >>> (j - 1));
					rvy_s[j]  <= rvy_s[j-1] - (rvx_s[j-1] >>> (j - 1));
					racc_s[j] <= racc_s[j-1] + rpry_pkg::ATAN_TAB[j-1];
				end
			end
		end
	end

	assign roll_fin  = rz_s[N] ? '0 : racc_s[N];
	assign pitch_fin = pz_d[PD-1] ? '0 : pacc_d[PD-1];
	assign roll_fld  = to_fld(roll_fin, rpry_pkg::LIM_ROLL);
	assign pitch_fld = to_fld(pitch_fin, rpry_pkg::LIM_PITCH);
	assign res       = {1'b0, pitch_fld, roll_fld[14:0]};

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= vld_s[P_LAST];
		end else if (vld_s[P_LAST]) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				m_tdata <= skid_q;
			end
		end else if (!m_tvalid || m_tready) begin
			m_tdata <= res;
		end else begin
			skid_q <= res;
		end
	end

endmodule
